// ===== design/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, codes and helpers shared by the websocket frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned LenW = 64;
  localparam int unsigned CntW = 4;
  localparam int unsigned KeyBytes = 4;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING = 4'h9;
  localparam logic [3:0] OPC_PONG = 4'hA;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_DELIVER = 3'd1;
  localparam logic [2:0] ACT_PONG_REPLY = 3'd2;
  localparam logic [2:0] ACT_PONG_IGNORE = 3'd3;
  localparam logic [2:0] ACT_CLOSE = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t                        phase;
    logic                          fin;
    logic [3:0]                    opcode;
    logic                          mask_on;
    logic [LenW-1:0]               remaining;
    logic [CntW-1:0]               byte_count;
    logic [KeyBytes-1:0][7:0]      mask_key;
  } state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       final_fragment;
    logic [2:0] end_action;
  } result_t;

  function automatic result_t make_result(input logic [7:0] pbyte, input logic has,
                                          input logic fend, input logic fin,
                                          input logic [3:0] opc);
    result_t r;
    logic [2:0] act;
    act = ACT_NONE;
    if (fend && fin) begin
      case (opc)
        OPC_CLOSE: act = ACT_CLOSE;
        OPC_PING:  act = ACT_PONG_REPLY;
        OPC_PONG:  act = ACT_PONG_IGNORE;
        default:   act = ACT_DELIVER;
      endcase
    end
    r.payload_byte = has ? pbyte : 8'd0;
    r.has_byte = has;
    r.frame_opcode = opc;
    r.frame_end = fend;
    r.final_fragment = fin;
    r.end_action = act;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side websocket frame parser: header, length, mask key, payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one received stream byte per request.
//   out_valid/out_ready carry one result per payload byte, plus one result
//   with has_byte low for a frame of zero length. Header bytes give none.
//   The result that ends a frame has frame_end high and, for a final
//   fragment, the action: deliver, pong reply, pong ignored or close.
//   A result is registered: it is on the outputs in the cycle after its byte is taken.
//   Throughput: one byte per cycle while in_ready is high; the parser state updates
//   in one pass between the state registers and the result register.
//   in_ready is high whenever the result register is empty or being taken,
//   so a stalled receiver holds one result and stops the input after it.
//   Reset (rst_n low, synchronous) returns the parser to the header byte,
//   clears the mask key and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_payload_byte,
  output logic            out_has_byte,
  output logic [3:0]      out_frame_opcode,
  output logic            out_frame_end,
  output logic            out_final_fragment,
  output logic [2:0]      out_end_action
);
  import wsd_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    emit;
  logic    out_valid_r;
  logic    in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc = in_valid && in_ready;

  wsd_step u_step (
    .st      (state_r),
    .in_byte (in_byte),
    .st_nxt  (state_nxt),
    .emit    (emit),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_payload_byte = res_r.payload_byte;
  assign out_has_byte = res_r.has_byte;
  assign out_frame_opcode = res_r.frame_opcode;
  assign out_frame_end = res_r.frame_end;
  assign out_final_fragment = res_r.final_fragment;
  assign out_end_action = res_r.end_action;

endmodule

`default_nettype wire

// ===== design/wsd_step.sv =====
// ----------------------------------------------------------------------------
// wsd_step
// Next-state and result logic for one received byte of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_step (
  input  wire wsd_pkg::state_t  st,
  input  wire logic [7:0]       in_byte,
  output wsd_pkg::state_t       st_nxt,
  output logic                  emit,
  output wsd_pkg::result_t      res
);
  import wsd_pkg::*;

  always_comb begin
    logic       len_known;
    logic       end_now;
    logic [6:0] len7;
    logic [1:0] key_idx;
    logic [7:0] pbyte;

    st_nxt = st;
    emit = 1'b0;
    res = '0;
    len_known = 1'b0;
    end_now = 1'b0;
    len7 = in_byte[6:0];
    key_idx = 2'd0 - st.byte_count[1:0];
    pbyte = in_byte ^ (st.mask_on ? st.mask_key[st.byte_count[1:0]] : 8'd0);

    case (st.phase)
      PH_LEN: begin
        st_nxt.mask_on = in_byte[7];
        if (len7 == LEN_CODE_EXT16) begin
          st_nxt.phase = PH_EXT16;
          st_nxt.remaining = '0;
          st_nxt.byte_count = EXT16_BYTES;
        end else if (len7 == LEN_CODE_EXT64) begin
          st_nxt.phase = PH_EXT64;
          st_nxt.remaining = '0;
          st_nxt.byte_count = EXT64_BYTES;
        end else begin
          st_nxt.remaining = {{(LenW-7){1'b0}}, len7};
          len_known = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        st_nxt.remaining = {st.remaining[LenW-9:0], in_byte};
        st_nxt.byte_count = st.byte_count - 4'd1;
        if (st_nxt.byte_count == 4'd0) begin
          len_known = 1'b1;
        end
      end
      PH_KEY: begin
        st_nxt.mask_key[key_idx] = in_byte;
        st_nxt.byte_count = st.byte_count - 4'd1;
        if (st_nxt.byte_count == 4'd0) begin
          if (st.remaining == '0) begin
            end_now = 1'b1;
          end else begin
            st_nxt.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        st_nxt.remaining = st.remaining - 64'd1;
        st_nxt.byte_count = st.byte_count + 4'd1;
        emit = 1'b1;
        res = make_result(pbyte, 1'b1, st_nxt.remaining == '0, st.fin, st.opcode);
        if (st_nxt.remaining == '0) begin
          st_nxt.phase = PH_HEADER;
          st_nxt.fin = 1'b0;
          st_nxt.opcode = 4'd0;
          st_nxt.mask_on = 1'b0;
          st_nxt.byte_count = '0;
        end
      end
      default: begin
        st_nxt.fin = in_byte[7];
        st_nxt.opcode = in_byte[3:0];
        st_nxt.phase = PH_LEN;
      end
    endcase

    // length settled: go to mask key, payload, or close an empty frame
    if (len_known) begin
      if (st_nxt.mask_on) begin
        st_nxt.phase = PH_KEY;
        st_nxt.byte_count = KEY_BYTES;
      end else if (st_nxt.remaining == '0) begin
        end_now = 1'b1;
      end else begin
        st_nxt.phase = PH_PAYLOAD;
        st_nxt.byte_count = '0;
      end
    end

    if (end_now) begin
      emit = 1'b1;
      res = make_result(8'd0, 1'b0, 1'b1, st.fin, st.opcode);
      st_nxt.phase = PH_HEADER;
      st_nxt.fin = 1'b0;
      st_nxt.opcode = 4'd0;
      st_nxt.mask_on = 1'b0;
      st_nxt.remaining = '0;
      st_nxt.byte_count = '0;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the websocket frame deframer. A short table of
// header, length, mask key and payload cases runs first, then random frames
// under varied sender and receiver idling, including a long receiver
// hold-off. Every result is checked against a table entry or an in-bench frame parser.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    logic [7:0] data;
    row_kind_t  kind;
    result_t    res;
  } stim_t;

  localparam result_t NoResult = '0;
  localparam int DirRows = 25;
  localparam int SegCount = 5;
  localparam int SegItems = 230;
  localparam int HoldCycles = 300;
  localparam int SendIdle [SegCount] = '{0, 59, 0, 8, 0};
  localparam int RecvStall [SegCount] = '{0, 0, 59, 8, 0};

  localparam stim_t DirectedRows [DirRows] = '{
    '{8'h81, ROW_NONE,  NoResult},
    '{8'h00, ROW_TYPED, '{8'h00, 1'b0, 4'h1, 1'b1, 1'b1, ACT_DELIVER}},
    '{8'h89, ROW_NONE,  NoResult},
    '{8'h00, ROW_TYPED, '{8'h00, 1'b0, OPC_PING, 1'b1, 1'b1, ACT_PONG_REPLY}},
    '{8'h78, ROW_NONE,  NoResult},
    '{8'h00, ROW_TYPED, '{8'h00, 1'b0, OPC_CLOSE, 1'b1, 1'b0, ACT_NONE}},
    '{8'h8A, ROW_PRED,  NoResult},
    '{8'hFE, ROW_PRED,  NoResult},
    '{8'h00, ROW_PRED,  NoResult},
    '{8'h01, ROW_PRED,  NoResult},
    '{8'h12, ROW_PRED,  NoResult},
    '{8'h34, ROW_PRED,  NoResult},
    '{8'h56, ROW_PRED,  NoResult},
    '{8'h78, ROW_PRED,  NoResult},
    '{8'hFF, ROW_PRED,  NoResult},
    '{8'h8F, ROW_NONE,  NoResult},
    '{8'h7F, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_NONE,  NoResult},
    '{8'h00, ROW_TYPED, '{8'h00, 1'b0, 4'hF, 1'b1, 1'b1, ACT_DELIVER}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_payload_byte;
  logic       out_has_byte;
  logic [3:0] out_frame_opcode;
  logic       out_frame_end;
  logic       out_final_fragment;
  logic [2:0] out_end_action;

  stim_t      cur_item = '0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       pressure_on = 1'b0;
  logic       hold_off = 1'b0;
  int         mismatch_cnt = 0;
  result_t    pending_results [$];
  stim_t      frame_q [$];

  // parser state
  phase_t      p_phase = PH_HEADER;
  logic        p_fin = 1'b0;
  logic [3:0]  p_opcode = 4'h0;
  logic        p_mask = 1'b0;
  logic [63:0] p_remaining = '0;
  logic [3:0]  p_count = '0;
  logic [7:0]  p_key [4] = '{8'h00, 8'h00, 8'h00, 8'h00};

  websocket_frame_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_byte   (out_payload_byte),
    .out_has_byte       (out_has_byte),
    .out_frame_opcode   (out_frame_opcode),
    .out_frame_end      (out_frame_end),
    .out_final_fragment (out_final_fragment),
    .out_end_action     (out_end_action)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic result_t frame_result(input logic [7:0] pbyte, input logic has,
                                           input logic fend);
    result_t r;
    r.payload_byte = has ? pbyte : 8'h00;
    r.has_byte = has;
    r.frame_opcode = p_opcode;
    r.frame_end = fend;
    r.final_fragment = p_fin;
    if (!(fend && p_fin)) r.end_action = ACT_NONE;
    else if (p_opcode == OPC_CLOSE) r.end_action = ACT_CLOSE;
    else if (p_opcode == OPC_PING) r.end_action = ACT_PONG_REPLY;
    else if (p_opcode == OPC_PONG) r.end_action = ACT_PONG_IGNORE;
    else r.end_action = ACT_DELIVER;
    return r;
  endfunction

  function automatic void close_frame();
    p_phase = PH_HEADER;
    p_fin = 1'b0;
    p_opcode = 4'h0;
    p_mask = 1'b0;
    p_remaining = '0;
    p_count = '0;
  endfunction

  // length complete: go to mask key, payload, or end an empty frame
  function automatic bit length_known(output result_t r);
    r = NoResult;
    if (p_mask) begin
      p_phase = PH_KEY;
      p_count = KEY_BYTES;
      return 1'b0;
    end
    if (p_remaining == 0) begin
      r = frame_result(8'h00, 1'b0, 1'b1);
      close_frame();
      return 1'b1;
    end
    p_phase = PH_PAYLOAD;
    p_count = '0;
    return 1'b0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [3:0] idx;
    logic [7:0] c;
    bit got;
    got = 1'b0;
    r = NoResult;
    case (p_phase)
      PH_LEN: begin
        p_mask = b[7];
        if (b[6:0] == LEN_CODE_EXT16) begin
          p_phase = PH_EXT16;
          p_remaining = '0;
          p_count = EXT16_BYTES;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          p_phase = PH_EXT64;
          p_remaining = '0;
          p_count = EXT64_BYTES;
        end else begin
          p_remaining = {57'd0, b[6:0]};
          got = length_known(r);
        end
      end
      PH_EXT16, PH_EXT64: begin
        p_remaining = {p_remaining[55:0], b};
        p_count = p_count - 4'd1;
        if (p_count == 0) got = length_known(r);
      end
      PH_KEY: begin
        idx = KEY_BYTES - p_count;
        p_key[idx[1:0]] = b;
        p_count = p_count - 4'd1;
        if (p_count == 0) begin
          if (p_remaining == 0) begin
            r = frame_result(8'h00, 1'b0, 1'b1);
            close_frame();
            got = 1'b1;
          end else begin
            p_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        c = p_mask ? (b ^ p_key[p_count[1:0]]) : b;
        p_remaining = p_remaining - 64'd1;
        p_count = p_count + 4'd1;
        r = frame_result(c, 1'b1, p_remaining == 0);
        if (p_remaining == 0) close_frame();
        got = 1'b1;
      end
      default: begin
        p_fin = b[7];
        p_opcode = b[3:0];
        p_phase = PH_LEN;
      end
    endcase
    return got;
  endfunction

  // sample at the falling edge: handshakes seen here complete at the next rising edge
  always @(negedge clk) begin : monitor
    result_t pred;
    result_t want;
    bit got;
    if (rst_n && in_valid && in_ready) begin
      got = deframe_byte(in_byte, pred);
      if (cur_item.kind == ROW_TYPED)
        pending_results.insert(pending_results.size(), cur_item.res);
      else if (cur_item.kind == ROW_PRED && got)
        pending_results.insert(pending_results.size(), pred);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = pending_results.pop_front();
        if (out_payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %h, want %h", out_payload_byte,
                                    want.payload_byte));
        if (out_has_byte !== want.has_byte)
          report_mismatch($sformatf("has_byte %b, want %b", out_has_byte, want.has_byte));
        if (out_frame_opcode !== want.frame_opcode)
          report_mismatch($sformatf("frame_opcode %h, want %h", out_frame_opcode,
                                    want.frame_opcode));
        if (out_frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b", out_frame_end, want.frame_end));
        if (out_final_fragment !== want.final_fragment)
          report_mismatch($sformatf("final_fragment %b, want %b", out_final_fragment,
                                    want.final_fragment));
        if (out_end_action !== want.end_action)
          report_mismatch($sformatf("end_action %0d, want %0d", out_end_action,
                                    want.end_action));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  // long receiver hold-off so the result register fills and input stalls
  initial begin
    wait (pressure_on);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_item(input stim_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= it.data;
    cur_item <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), '{b, ROW_PRED, NoResult});
  endfunction

  task automatic queue_frame(input bit noisy);
    logic [7:0]  hdr;
    logic        mask;
    logic [63:0] len;
    int          sel;
    hdr = 8'($urandom_range(0, 255));
    if (!noisy && $urandom_range(0, 3) == 0) hdr[3:0] = OPC_CLOSE + 4'($urandom_range(0, 2));
    mask = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    add_byte(hdr);
    if (noisy) begin
      len = 64'($urandom_range(0, 125));
      add_byte({mask, len[6:0]});
    end else if (sel < 6) begin
      len = 64'($urandom_range(0, 20));
      add_byte({mask, len[6:0]});
    end else if (sel < 8) begin
      len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                         : 64'($urandom_range(0, 30));
      add_byte({mask, LEN_CODE_EXT16});
      add_byte(len[15:8]);
      add_byte(len[7:0]);
    end else begin
      len = 64'($urandom_range(0, 30));
      add_byte({mask, LEN_CODE_EXT64});
      for (int i = 7; i >= 0; i--) add_byte(len[8*i +: 8]);
    end
    if (mask) for (int i = 0; i < 4; i++) add_byte(8'($urandom_range(0, 255)));
    for (longint i = 0; i < longint'(len); i++) add_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int seg_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DirRows; i++) send_item(DirectedRows[i]);
    for (int seg = 0; seg < SegCount; seg++) begin
      send_idle_pct = SendIdle[seg];
      stall_pct <= RecvStall[seg];
      if (seg == SegCount - 1) pressure_on <= 1'b1;
      seg_items = 0;
      while (seg_items < SegItems) begin
        queue_frame($urandom_range(0, 7) == 0);
        while (frame_q.size() != 0) begin
          send_item(frame_q.pop_front());
          seg_items++;
        end
      end
    end
    // oversized 64-bit length with the top bit set, left open at the end
    add_byte(8'h82);
    add_byte({1'b1, LEN_CODE_EXT64});
    for (int i = 0; i < 8; i++) add_byte(8'hFF);
    for (int i = 0; i < 4; i++) add_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < 12; i++) add_byte(8'($urandom_range(0, 255)));
    while (frame_q.size() != 0) send_item(frame_q.pop_front());
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && pending_results.size() != 0; i++) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wsd_pkg.sv
design/wsd_step.sv
design/websocket_frame_deframer.sv
bench/tb.sv
